FILE: rtl/core/poc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package poc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_BITS  = 32;
  localparam int REG_BYTES   = 16;
  localparam int WIN_DEPTH   = REG_BYTES - 1;
  localparam int LEN_BITS    = 5;
  localparam int OUT_BITS    = 32;
  localparam int LEN_CAP     = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int WIDE_BITS   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [7:0]            byte_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] file_count;
    logic        match_here;
    logic        file_done;
    logic        new_best;
    logic [31:0] best_count;
  } out_item_t;

  function automatic logic [OUT_BITS-1:0] sat_out(input count_t v);
    logic [WIDE_BITS-1:0] ext;
    logic [WIDE_BITS-1:0] lim;
    begin
      ext = WIDE_BITS'(v);
      lim = WIDE_BITS'({OUT_BITS{1'b1}});
      if (ext > lim) begin
        sat_out = '1;
      end else begin
        sat_out = ext[OUT_BITS-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/poc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module poc_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire poc_pkg::byte_t byte_in,
  input  wire logic          cmp_en,
  input  wire poc_pkg::byte_t pat_byte,
  output poc_pkg::byte_t     byte_out,
  output logic               eq
);
  import poc_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? byte_in : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;
  assign eq       = !cmp_en || (byte_r == pat_byte);

endmodule
`default_nettype wire

FILE: rtl/core/poc_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
module poc_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire poc_pkg::out_item_t item_in,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output poc_pkg::out_item_t      out_item
);
  import poc_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t skid_item_r, skid_item_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (take) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_item_nxt  = item_in;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = item_in;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: rtl/core/pattern_occurrence_counter.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_stall     | in_item (data_byte, line_end, file_end)
// out     | output    | out_valid / out_stall   | out_item (counts and flags)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; its result is registered into the output buffer.
// All window compares run at once in a row of 15 byte cells.
// A two-entry output buffer takes one more byte while out_stall holds the first entry;
// in_stall rises only while both entries are held.
// rst_n is synchronous: clears the window, counts, best and pattern registers.
`timescale 1ns / 1ps
`default_nettype none
module pattern_occurrence_counter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire poc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output poc_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import poc_pkg::*;

  len_t        pattern_length_r, pattern_length_nxt;
  logic [63:0] pattern_low_r, pattern_low_nxt;
  logic [63:0] pattern_high_r, pattern_high_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [3:0]  skip_r, skip_nxt;
  count_t      running_r, running_nxt;
  count_t      best_r, best_nxt;

  byte_t       pat_bytes [REG_BYTES];
  byte_t       win_bytes [WIN_DEPTH];
  byte_t       cell_pat  [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] cell_en;
  logic [WIN_DEPTH-1:0] cell_eq;
  len_t        len_eff;
  len_t        last_idx;
  logic        accept;
  logic        match;
  logic        better;
  count_t      count_inc;
  out_item_t   result;
  logic        buf_full;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;

  always_comb begin
    pattern_length_nxt = pattern_length_r;
    pattern_low_nxt    = pattern_low_r;
    pattern_high_nxt   = pattern_high_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length_nxt = cfg_data[LEN_BITS-1:0];
        CFG_PATTERN_LOW:    pattern_low_nxt    = cfg_data;
        CFG_PATTERN_HIGH:   pattern_high_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < REG_BYTES; k++) begin
      pat_bytes[k] = (k < 8) ? pattern_low_r[8*(k%8) +: 8] : pattern_high_r[8*(k%8) +: 8];
    end
  end

  assign len_eff  = (pattern_length_r > len_t'(LEN_CAP)) ? len_t'(LEN_CAP) : pattern_length_r;
  assign last_idx = len_eff - len_t'(1);

  generate
    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
      len_t pidx;
      assign pidx        = len_eff - len_t'(j + 2);
      assign cell_en[j]  = len_eff >= len_t'(j + 2);
      assign cell_pat[j] = pat_bytes[pidx[3:0]];
      poc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .byte_in  ((j == 0) ? in_item.data_byte : win_bytes[(j == 0) ? 0 : j - 1]),
        .cmp_en   (cell_en[j]),
        .pat_byte (cell_pat[j]),
        .byte_out (win_bytes[j]),
        .eq       (cell_eq[j])
      );
    end
  endgenerate

  always_comb begin
    match = (len_eff != '0) && (skip_r == '0)
         && ({1'b0, fill_r} + len_t'(1) >= len_eff)
         && (pat_bytes[last_idx[3:0]] == in_item.data_byte)
         && (&cell_eq);

    count_inc = running_r;
    if (match && (running_r != '1)) begin
      count_inc = running_r + count_t'(1);
    end

    if (match) begin
      skip_nxt = last_idx[3:0];
    end else if (skip_r != '0) begin
      skip_nxt = skip_r - 4'd1;
    end else begin
      skip_nxt = skip_r;
    end
    fill_nxt = (fill_r != 4'd15) ? fill_r + 4'd1 : fill_r;
    if (in_item.line_end || in_item.file_end) begin
      skip_nxt = '0;
      fill_nxt = '0;
    end

    better      = 1'b0;
    best_nxt    = best_r;
    running_nxt = count_inc;
    if (in_item.file_end) begin
      running_nxt = '0;
      if (count_inc > best_r) begin
        better   = 1'b1;
        best_nxt = count_inc;
      end
    end

    result.file_count = sat_out(count_inc);
    result.match_here = match;
    result.file_done  = in_item.file_end;
    result.new_best   = better;
    result.best_count = sat_out(best_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      fill_r           <= '0;
      skip_r           <= '0;
      running_r        <= '0;
      best_r           <= '0;
    end else begin
      pattern_length_r <= pattern_length_nxt;
      pattern_low_r    <= pattern_low_nxt;
      pattern_high_r   <= pattern_high_nxt;
      if (accept) begin
        fill_r    <= fill_nxt;
        skip_r    <= skip_nxt;
        running_r <= running_nxt;
        best_r    <= best_nxt;
      end
    end
  end

  poc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .item_in   (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: rtl/core/poc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module poc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire poc_pkg::out_item_t out_item
);
  import poc_pkg::*;

  logic [31:0] last_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_best_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_best_r <= out_item.best_count;
    end
  end

  a_best_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.new_best |-> out_item.file_done)
    else $error("new_best without file_done");

  a_best_equals_file: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.new_best |-> out_item.best_count == out_item.file_count)
    else $error("new best differs from file count");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.best_count >= last_best_r)
    else $error("best count decreased");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.match_here |-> out_item.file_count != '0)
    else $error("match with zero file count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed");

endmodule

bind pattern_occurrence_counter poc_checker u_poc_checker (.*);
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import poc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 146;
  localparam int STALL_PCT = 35;
  localparam int WATCHDOG_LIMIT = 2000;

  class occurrence_scoreboard;
    len_t        pat_len;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    byte_t       window[WIN_DEPTH];
    int          line_fill;
    int          skip_left;
    count_t      file_total;
    count_t      best;
    out_item_t   expected_results[$];
    int          mismatches;

    function new();
      pat_len = '0;
      pat_lo = '0;
      pat_hi = '0;
      foreach (window[k]) window[k] = '0;
      line_fill = 0;
      skip_left = 0;
      file_total = '0;
      best = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_PATTERN_LENGTH: pat_len = val[LEN_BITS-1:0];
        CFG_PATTERN_LOW: pat_lo = val;
        CFG_PATTERN_HIGH: pat_hi = val;
        default: ;
      endcase
    endfunction

    function byte_t pattern_byte(int k);
      return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
    endfunction

    function int active_length();
      return (int'(pat_len) > LEN_CAP) ? LEN_CAP : int'(pat_len);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void take_byte(in_item_t it);
      out_item_t res;
      int len;
      bit hit;
      len = active_length();
      hit = 1'b0;
      if (len > 0 && skip_left == 0 && line_fill + 1 >= len &&
          pattern_byte(len - 1) == it.data_byte) begin
        hit = 1'b1;
        for (int k = 0; k + 1 < len; k++) begin
          if (pattern_byte(k) != window[len - 2 - k]) hit = 1'b0;
        end
      end
      if (hit) begin
        if (file_total != '1) file_total++;
        skip_left = len - 1;
      end else if (skip_left > 0) begin
        skip_left--;
      end
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = it.data_byte;
      if (line_fill < WIN_DEPTH) line_fill++;
      if (it.line_end || it.file_end) begin
        line_fill = 0;
        skip_left = 0;
      end
      res.file_count = file_total;
      res.match_here = hit;
      res.file_done = it.file_end;
      res.new_best = 1'b0;
      if (it.file_end) begin
        if (file_total > best) begin
          best = file_total;
          res.new_best = 1'b1;
        end
        file_total = '0;
      end
      res.best_count = best;
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, file_count %0d best_count %0d", $time,
                 got.file_count, got.best_count);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.file_count !== want.file_count) begin
        $display("%0t: file_count expected %0d actual %0d", $time, want.file_count,
                 got.file_count);
        mismatches++;
      end
      if (got.match_here !== want.match_here) begin
        $display("%0t: match_here expected %0b actual %0b", $time, want.match_here,
                 got.match_here);
        mismatches++;
      end
      if (got.file_done !== want.file_done) begin
        $display("%0t: file_done expected %0b actual %0b", $time, want.file_done,
                 got.file_done);
        mismatches++;
      end
      if (got.new_best !== want.new_best) begin
        $display("%0t: new_best expected %0b actual %0b", $time, want.new_best,
                 got.new_best);
        mismatches++;
      end
      if (got.best_count !== want.best_count) begin
        $display("%0t: best_count expected %0d actual %0d", $time, want.best_count,
                 got.best_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_stall;
  logic        out_valid;
  logic        cfg_ready;
  out_item_t   out_item;

  bit    no_idle = 1'b0;
  byte_t alphabet[4];
  int    quiet_cycles = 0;
  int    phase_lengths[8] = '{1, 2, 4, 0, 3, 16, 31, 16};
  occurrence_scoreboard sb = new();

  pattern_occurrence_counter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pattern_occurrence_counter test failed");
      $finish;
    end
  end

  task automatic send_item(byte_t b, bit le, bit fe);
    in_item_t it;
    it.data_byte = b;
    it.line_end = le;
    it.file_end = fe;
    if (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int len, logic [63:0] lo, logic [63:0] hi);
    logic [63:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[4:0] = len[4:0];
    write_reg(CFG_PATTERN_LENGTH, len_word);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_t text_byte();
    if ($urandom_range(3) != 0) return alphabet[$urandom_range(3)];
    return byte_t'($urandom_range(255));
  endfunction

  // mostly whole or nearly whole occurrences mixed with alphabet noise
  task automatic send_text(int count);
    int sent;
    int len;
    byte_t b;
    sent = 0;
    len = sb.active_length();
    while (sent < count) begin
      if (len > 0 && $urandom_range(99) < 45) begin
        for (int k = 0; k < len && sent < count; k++) begin
          b = sb.pattern_byte(k);
          if ($urandom_range(99) < 3) b = text_byte();
          send_item(b, $urandom_range(39) == 0, $urandom_range(99) == 0);
          sent++;
        end
      end else begin
        send_item(text_byte(), $urandom_range(15) == 0, $urandom_range(59) == 0);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int len;
    logic [63:0] lo;
    logic [63:0] hi;
    byte_t pool[3];
    string script;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // zero length after reset: nothing counted, file end still compared
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    in_valid <= 1'b0;
    drain();

    // "aab": sliding restart, no match across a line end, matches on line/file end
    configure(3, 64'hFFFF_FFFF_FF62_6161, '1);
    script = "aaabaabaabaab";
    for (int i = 0; i < script.len(); i++) begin
      send_item(script[i], i == 5 || i == 9, i == 12);
    end
    in_valid <= 1'b0;
    drain();

    // oversize length clamps to 16
    write_reg(CFG_SPARE, {$urandom, $urandom});
    configure(31, '1, '1);
    for (int i = 0; i < 16; i++) send_item(8'hFF, 1'b0, i == 15);
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      len = (p < 8) ? phase_lengths[p] : $urandom_range(31);
      for (int k = 0; k < 3; k++) pool[k] = byte_t'($urandom_range(255));
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pool[$urandom_range(2)];
        hi[8*k +: 8] = pool[$urandom_range(2)];
      end
      if ($urandom_range(9) < 3) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      if (p == 2) begin
        lo = '0;
        hi = '0;
      end
      if (p == 7) begin
        lo = '1;
        hi = '1;
      end
      no_idle = (p == 5);
      drain();
      configure(len, lo, hi);
      alphabet[0] = sb.pattern_byte(0);
      alphabet[1] = pool[0];
      alphabet[2] = sb.pattern_byte(1);
      alphabet[3] = byte_t'($urandom_range(255));
      send_text(PHASE_ITEMS);
    end
    no_idle = 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pattern_occurrence_counter test passed");
    end else begin
      $display("pattern_occurrence_counter test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/poc_pkg.sv
rtl/core/poc_cell.sv
rtl/core/poc_outbuf.sv
rtl/core/pattern_occurrence_counter.sv
rtl/core/poc_checker.sv
verif/tb_top.sv
